[rtl/core/spq_pkg.sv]
// Package for the sorted priority queue: sizes, entry type, request and
// status codes, and the control word broadcast to the row of cells.
// Depends on nothing.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 16;
  localparam int ID_BITS  = 8;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    logic   rmv;
    entry_t item;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/spq_cell.sv]
// One slot of the ordered store: holds an entry, compares it with the request
// and takes its own, its left or its right neighbour's entry, or the new one.
// Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  logic      clk,
  input  logic      load,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  entry_t    left,
  input  logic      left_gt,
  input  logic      left_hit,
  input  entry_t    right,
  output entry_t    entry,
  output logic      gt,
  output logic      hit,
  output logic      first
);

  entry_t entry_next;
  logic   match;

  always_comb begin
    gt         = !(occ && (entry.key <= ctl.item.key));
    match      = ctl.rmv && occ && (entry.id == ctl.item.id);
    hit        = left_hit | match;
    first      = match && !left_hit;
    entry_next = entry;
    priority if (ctl.ins && gt) begin
      // shift right, or take the new word at the insertion point
      entry_next = left_gt ? left : ctl.item;
    end else if ((ctl.pop || ctl.rmv) && hit) begin
      entry_next = right;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sorted_priority_queue.sv]
// Sorted priority queue built as a row of compare-and-shift cells.
// Depends on spq_pkg and spq_cell.
//
// Use: requests arrive on the req channel (req_valid/req_ready) with
// req_type (insert, pop smallest, remove by id), item_id and item_key.
// Each request gives exactly one word on the rsp channel (rsp_valid/
// rsp_ready): status, the entry taken out by pop or remove, the entry count
// and the head entry after the request.
// The response word is registered: it appears in the cycle after acceptance.
// Throughput: one request per cycle while the receiver takes each response
// word; every cell compares its slot with the request and shifts in the same
// cycle, so the row of 16 cells sets the figure, not any iteration.
// Inserts go after all entries of equal or smaller key; ties leave in
// arrival order. Pop when empty, insert when full and remove of an absent
// id change nothing and are flagged in status.
// Reset empties the queue and drops any pending response word.
// When the receiver stalls, the response word is held and req_ready drops
// until it is taken; the queue contents are held with it.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [1:0]          req_type,
  input  logic [ID_BITS-1:0]  item_id,
  input  logic [KEY_BITS-1:0] item_key,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [1:0]          status,
  output logic [ID_BITS-1:0]  taken_id,
  output logic [KEY_BITS-1:0] taken_key,
  output logic [CNT_BITS-1:0] entry_count,
  output logic                head_valid,
  output logic [ID_BITS-1:0]  head_id,
  output logic [KEY_BITS-1:0] head_key
);

  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic                accept;
  logic                full;
  logic                empty;
  cell_ctl_t           ctl;
  status_t             status_next;
  entry_t              taken_next;
  entry_t              taken;
  status_t             status_q;

  entry_t ent     [CAPACITY];
  logic   occ     [CAPACITY];
  logic   gt_v    [CAPACITY];
  logic   hit_v   [CAPACITY];
  logic   first_v [CAPACITY];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CNT_BITS'(CAPACITY));
  assign empty     = (count == '0);

  always_comb begin
    ctl         = '0;
    ctl.item.id = item_id;
    ctl.item.key = item_key;
    unique case (req_t'(req_type))
      REQ_INSERT: ctl.ins = !full;
      REQ_POP:    ctl.pop = !empty;
      REQ_REMOVE: ctl.rmv = 1'b1;
      default:    ;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (count > CNT_BITS'(i));

    spq_cell u_cell (
      .clk      (clk),
      .load     (accept),
      .ctl      (ctl),
      .occ      (occ[i]),
      .left     ((i == 0) ? '0 : ent[(i == 0) ? 0 : i - 1]),
      .left_gt  ((i == 0) ? 1'b0 : gt_v[(i == 0) ? 0 : i - 1]),
      .left_hit ((i == 0) ? (ctl.pop && occ[0]) : hit_v[(i == 0) ? 0 : i - 1]),
      .right    ((i == CAPACITY - 1) ? '0 : ent[(i == CAPACITY - 1) ? i : i + 1]),
      .entry    (ent[i]),
      .gt       (gt_v[i]),
      .hit      (hit_v[i]),
      .first    (first_v[i])
    );
  end

  always_comb begin
    taken_next  = '0;
    status_next = ST_OK;
    count_next  = count;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_v[i]) begin
        taken_next = taken_next | ent[i];
      end
    end
    unique case (req_t'(req_type))
      REQ_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_BITS'(1);
        end
      end
      REQ_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          taken_next = ent[0];
          count_next = count - CNT_BITS'(1);
        end
      end
      REQ_REMOVE: begin
        if (hit_v[CAPACITY-1]) begin
          count_next = count - CNT_BITS'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: status_next = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      taken    <= taken_next;
    end
  end

  assign status      = status_q;
  assign taken_id    = taken.id;
  assign taken_key   = taken.key;
  assign entry_count = count;
  assign head_valid  = !empty;
  assign head_id     = empty ? '0 : ent[0].id;
  assign head_key    = empty ? '0 : ent[0].key;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(CAPACITY))
    else $error("entry count beyond capacity");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(count) && $stable(status_q) &&
      $stable(head_id) && $stable(head_key))
    else $error("state changed while response stalled");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_POP && empty |=> status_q == ST_EMPTY && count == '0)
    else $error("pop on empty queue not flagged");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_INSERT && !full |=> count == $past(count) + CNT_BITS'(1))
    else $error("insert did not grow the queue");
`endif

endmodule

`default_nettype wire
